@@ rtl/core/rof_pkg.sv @@
// ---------------------------------------------------------------------------
// rof_pkg: shared types and constants of the radius outlier filter
// Point layout, field widths, register indexes and item kinds.
// ---------------------------------------------------------------------------
package rof_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int COUNT_W    = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 20;
  localparam int POINT_W    = 3 * COORD_W;
  localparam int RADIUS_W   = 16;
  localparam int NB_W       = 10;
  localparam int R2_W       = 2 * RADIUS_W;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int D2_W       = SQ_W + 2;

  // RAM read plus three distance stages
  localparam int PIPE_DEPTH = 4;

  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_MIN_NB = 1'b1;

  localparam logic KIND_LOAD     = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_INDEX = 1'b1;

  // x in the lowest bits
  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic valid;
    logic self;
  } dist_tag_t;

endpackage

@@ rtl/core/radius_outlier_filter.sv @@
// ---------------------------------------------------------------------------
// radius_outlier_filter: radius outlier classification over a point store
// Loads 3-D points into a RAM and classifies stored points by neighbor count.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries items. tuser[0] is the kind (load or classify), tuser[1]
//   starts a new frame on a load. A load gives no result; loads past
//   capacity are dropped and set the overflow flag.
//   A classify item reads the query point, then scans the store one point
//   per cycle through a single RAM read port and a 3-stage distance
//   pipeline. Its result follows the scan of all N stored points, sooner
//   when the neighbor count reaches min_nb early (the scan stops then),
//   and comes without a scan for an index beyond the stored count;
//   s_tready rises again together with m_tvalid.
//   m_* carries one result per classify item from an output register;
//   s_tready stays low while a classify runs and while its result cannot
//   be placed because m_* is stalled. Loads are taken while a result waits.
//   cfg_* writes search_radius_mm (index 0) and min_nb (index 1), always
//   ready; the user must write only while the block is idle (not enforced).
//   Reset empties the store, clears overflow and loads radius 100 and
//   min_nb 3. The RAM itself needs no clearing.
// ---------------------------------------------------------------------------
module radius_outlier_filter import rof_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [71:0]         s_tdata,   // x_mm, y_mm, z_mm, query_pos, 2 pad bits
  input  logic [1:0]          s_tuser,   // kind, new_frame
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [23:0]         m_tdata,   // point_index, keep, nb_count, overflow,
                                         // 2 pad bits
  output logic                m_tuser,   // status
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [RADIUS_W-1:0] cfg_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_QREAD = 3'd1;
  localparam logic [2:0] ST_QLAT  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam int DRAIN_W = $clog2(PIPE_DEPTH + 1);
  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_POINTS);

  logic [2:0]          state;
  logic [COUNT_W-1:0]  count;
  logic                overflow_seen;
  logic [RADIUS_W-1:0] radius;
  logic [NB_W-1:0]     min_nb;
  logic [R2_W-1:0]     r2;
  logic [ADDR_W-1:0]   q;
  logic [ADDR_W-1:0]   j;
  logic [NB_W-1:0]     found;
  logic                bad_q;
  logic [DRAIN_W-1:0]  drain_cnt;
  point_t              qpoint;
  point_t              rdata;
  dist_tag_t           rd_tag;
  logic                hit;

  logic                accept;
  logic                is_load;
  logic                new_frame;
  logic [ADDR_W-1:0]   in_query;
  logic [COUNT_W-1:0]  base;
  logic                full;
  logic                we;
  logic [ADDR_W-1:0]   raddr;
  logic                issue;
  logic                last_j;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign is_load   = (s_tuser[0] == KIND_LOAD);
  assign new_frame = s_tuser[1];
  assign in_query  = s_tdata[POINT_W +: ADDR_W];

  assign base  = new_frame ? '0 : count;
  assign full  = (base == MAX_COUNT);
  assign we    = accept && is_load && !full;
  assign raddr = (state == ST_QREAD) ? q : j;

  assign issue  = (state == ST_SCAN) && (found < min_nb);
  assign last_j = ((COUNT_W'(j) + COUNT_W'(1)) == count);

  rof_ram #(
    .WIDTH (POINT_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (base[ADDR_W-1:0]),
    .wdata (s_tdata[POINT_W-1:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  rof_dist u_dist (
    .clk (clk),
    .rst (rst),
    .tag (rd_tag),
    .pa  (qpoint),
    .pb  (rdata),
    .r2  (r2),
    .hit (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_W'(100);
      min_nb <= NB_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RADIUS: radius <= cfg_data;
        CFG_MIN_NB: min_nb <= cfg_data[NB_W-1:0];
        default: ;
      endcase
    end
    r2 <= R2_W'(radius) * R2_W'(radius);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      overflow_seen <= 1'b0;
      rd_tag        <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      rd_tag.valid <= issue;
      rd_tag.self  <= (j == q);
      // raise on a placed result, drop once the result transaction completes
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (is_load) begin
              if (full) begin
                count         <= base;
                overflow_seen <= 1'b1;
              end else begin
                count         <= base + COUNT_W'(1);
                overflow_seen <= new_frame ? 1'b0 : overflow_seen;
              end
            end else if (COUNT_W'(in_query) >= count) begin
              state <= ST_DONE;
            end else begin
              state <= ST_QREAD;
            end
          end
        end
        ST_QREAD: state <= ST_QLAT;
        ST_QLAT:  state <= ST_SCAN;
        ST_SCAN: begin
          if (!issue || last_j) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drain_cnt == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold the result until the output register frees up
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && !is_load) begin
      q     <= in_query;
      bad_q <= (COUNT_W'(in_query) >= count);
      found <= '0;
      j     <= '0;
    end else begin
      if (hit && found < min_nb) begin
        found <= found + NB_W'(1);
      end
      if (issue) begin
        j <= j + ADDR_W'(1);
      end
    end
    if (state == ST_QLAT) begin
      qpoint <= rdata;
    end
    drain_cnt <= (state == ST_DRAIN) ? drain_cnt - DRAIN_W'(1) : DRAIN_W'(PIPE_DEPTH);
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata[ADDR_W-1:0] <= q;
      m_tdata[ADDR_W]     <= !bad_q && (found >= min_nb);
      m_tdata[ADDR_W+1 +: NB_W] <= bad_q ? '0 : found;
      m_tdata[ADDR_W+NB_W+1]    <= overflow_seen;
      m_tdata[23:ADDR_W+NB_W+2] <= '0;
      m_tuser <= bad_q ? STATUS_BAD_INDEX : STATUS_OK;
    end
  end

endmodule

@@ rtl/core/rof_ram.sv @@
// ---------------------------------------------------------------------------
// rof_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module rof_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/rof_dist.sv @@
// ---------------------------------------------------------------------------
// rof_dist: pipelined squared-distance compare
// Three stages: absolute differences, squares, sum and radius compare.
// ---------------------------------------------------------------------------
module rof_dist import rof_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  dist_tag_t       tag,
  input  point_t          pa,
  input  point_t          pb,
  input  logic [R2_W-1:0] r2,
  output logic            hit
);

  logic signed [COORD_W:0] dx, dy, dz;
  logic [COORD_W-1:0]      ax, ay, az;
  logic [SQ_W-1:0]         sx, sy, sz;
  logic [D2_W-1:0]         d2;
  dist_tag_t               tag1, tag2;

  assign dx = $signed({pb.x[COORD_W-1], pb.x}) - $signed({pa.x[COORD_W-1], pa.x});
  assign dy = $signed({pb.y[COORD_W-1], pb.y}) - $signed({pa.y[COORD_W-1], pa.y});
  assign dz = $signed({pb.z[COORD_W-1], pb.z}) - $signed({pa.z[COORD_W-1], pa.z});
  assign d2 = D2_W'(sx) + D2_W'(sy) + D2_W'(sz);

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
      tag2 <= '0;
      hit  <= 1'b0;
    end else begin
      tag1 <= tag;
      tag2 <= tag1;
      hit  <= tag2.valid && !tag2.self && (d2 <= D2_W'(r2));
    end
    ax <= dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ay <= dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    az <= dz[COORD_W] ? COORD_W'(-dz) : dz[COORD_W-1:0];
    sx <= SQ_W'(ax) * SQ_W'(ax);
    sy <= SQ_W'(ay) * SQ_W'(ay);
    sz <= SQ_W'(az) * SQ_W'(az);
  end

endmodule

@@ rtl/core/rof_checker.sv @@
// ---------------------------------------------------------------------------
// rof_checker: port-level checks of the radius outlier filter
// Watches the top-level ports only; attached by bind.
// ---------------------------------------------------------------------------
module rof_checker import rof_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [1:0]          s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [23:0]         m_tdata,
  input logic                m_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // a bad index yields keep 0 and count 0
  a_bad_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == STATUS_BAD_INDEX) |-> (m_tdata[20:10] == '0))
    else $error("bad index result carries keep or count");

  // a load transaction never produces a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == KIND_LOAD) && !m_tvalid |=> !m_tvalid)
    else $error("result appeared after a load");

  // a classify transaction occupies the block
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser[0] == KIND_CLASSIFY) |=> !s_tready)
    else $error("input taken right after a classify");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind radius_outlier_filter rof_checker u_rof_checker (.*);

@@ verif/radius_outlier_filter_checker.sv @@
// ---------------------------------------------------------------------------
// radius_outlier_filter_checker: result predictor and scoreboard
// Mirrors the point store and the filter registers from the transactions on
// the item and register channels, computes the expected verdict of every
// classify item and compares each result transaction with it.
// ---------------------------------------------------------------------------
module radius_outlier_filter_checker import rof_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [71:0]         s_tdata,   // x_mm, y_mm, z_mm, query_pos, 2 pad bits
  input  logic [1:0]          s_tuser,   // kind, new_frame
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [23:0]         m_tdata,   // point_index, keep, nb_count, overflow,
                                         // 2 pad bits
  input  logic                m_tuser,   // status
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [RADIUS_W-1:0] cfg_data,
  output int                  pending,
  output int                  failures
);

  typedef struct packed {
    logic [ADDR_W-1:0] point_index;
    logic              keep;
    logic [NB_W-1:0]   nb_count;
    logic              status;
    logic              overflow;
  } verdict_t;

  point_t               cloud [MAX_POINTS];
  logic [COUNT_W-1:0]   stored;
  logic                 overflow_seen;
  logic [RADIUS_W-1:0]  radius;
  logic [NB_W-1:0]      min_nb;
  verdict_t             expected_verdicts [$];

  task automatic report(string msg);
    $display("%0t radius_outlier_filter_checker: %s", $time, msg);
    failures++;
  endtask

  // Count other stored points inside the sphere, stopping at min_nb.
  function automatic verdict_t classify_point(logic [ADDR_W-1:0] q);
    verdict_t v;
    longint   dx, dy, dz, r2;
    int       found;
    v.point_index = q;
    v.keep        = 1'b0;
    v.nb_count    = '0;
    v.status      = STATUS_OK;
    v.overflow    = overflow_seen;
    if (q >= stored) begin
      v.status = STATUS_BAD_INDEX;
      return v;
    end
    r2    = longint'(radius) * longint'(radius);
    found = 0;
    for (int j = 0; j < stored && found < min_nb; j++) begin
      if (j == q) continue;
      dx = longint'($signed(cloud[ADDR_W'(j)].x)) - longint'($signed(cloud[q].x));
      dy = longint'($signed(cloud[ADDR_W'(j)].y)) - longint'($signed(cloud[q].y));
      dz = longint'($signed(cloud[ADDR_W'(j)].z)) - longint'($signed(cloud[q].z));
      if (dx * dx + dy * dy + dz * dz <= r2) found++;
    end
    v.nb_count = found[NB_W-1:0];
    v.keep     = (found >= min_nb);
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want, got;
    if (rst) begin
      stored        = '0;
      overflow_seen = 1'b0;
      radius        = 16'd100;
      min_nb        = 10'd3;
      failures      = 0;
      expected_verdicts.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_RADIUS) radius = cfg_data;
        else                         min_nb = cfg_data[NB_W-1:0];
      end

      if (m_tvalid && m_tready) begin
        got.point_index = m_tdata[9:0];
        got.keep        = m_tdata[10];
        got.nb_count    = m_tdata[20:11];
        got.overflow    = m_tdata[21];
        got.status      = m_tuser;
        if (expected_verdicts.size() == 0) begin
          report($sformatf("result for point %0d with no classify outstanding",
                           got.point_index));
        end else begin
          want = expected_verdicts.pop_front();
          if (got.point_index != want.point_index)
            report($sformatf("point_index got %0d want %0d",
                             got.point_index, want.point_index));
          if (got.keep != want.keep)
            report($sformatf("point %0d: keep got %0d want %0d",
                             want.point_index, got.keep, want.keep));
          if (got.nb_count != want.nb_count)
            report($sformatf("point %0d: nb_count got %0d want %0d",
                             want.point_index, got.nb_count, want.nb_count));
          if (got.status != want.status)
            report($sformatf("point %0d: status got %0d want %0d",
                             want.point_index, got.status, want.status));
          if (got.overflow != want.overflow)
            report($sformatf("point %0d: overflow got %0d want %0d",
                             want.point_index, got.overflow, want.overflow));
        end
      end

      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == KIND_LOAD) begin
          if (s_tuser[1]) begin
            stored        = '0;
            overflow_seen = 1'b0;
          end
          if (stored < MAX_POINTS) begin
            cloud[stored[ADDR_W-1:0]] = point_t'(s_tdata[POINT_W-1:0]);
            stored++;
          end else begin
            overflow_seen = 1'b1;
          end
        end else begin
          expected_verdicts.insert(expected_verdicts.size(),
                                   classify_point(s_tdata[POINT_W +: ADDR_W]));
        end
      end

      pending <= expected_verdicts.size();
    end
  end

endmodule

@@ verif/radius_outlier_filter_tb.sv @@
// ---------------------------------------------------------------------------
// radius_outlier_filter_tb: top level testbench of the radius outlier filter
// Drives directed point clouds and random clustered frames, with random gaps
// and back-pressure; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module radius_outlier_filter_tb;
  import rof_pkg::*;

  localparam int RANDOM_ITEMS  = 530;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 5000;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [71:0]         s_tdata   = '0;   // x_mm, y_mm, z_mm, query_pos, 2 pad bits
  logic [1:0]          s_tuser   = '0;   // kind, new_frame
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [23:0]         m_tdata;          // point_index, keep, nb_count, overflow,
                                         // 2 pad bits
  logic                m_tuser;          // status
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = CFG_RADIUS;
  logic [RADIUS_W-1:0] cfg_data  = '0;
  int                  pending;
  int                  failures;

  bit gaps_on   = 1'b1;
  bit stalls_on = 1'b1;
  int ready_hold  = 0;
  int idle_cycles = 0;
  int items_sent  = 0;
  int cur_radius  = 100;

  radius_outlier_filter dut (.*);
  radius_outlier_filter_checker checker_i (.*);

  always #4 clk = ~clk;

  // Result side back-pressure: mostly short stalls, now and then a long one.
  always @(posedge clk) begin
    int pick;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!stalls_on) begin
      m_tready <= 1'b1;
    end else begin
      pick = $urandom_range(0, 99);
      m_tready   <= (pick < 60);
      ready_hold <= (pick < 90) ? $urandom_range(0, 3) : $urandom_range(10, 40);
    end
  end

  // Give up when no transaction of any kind has happened for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("[radius_outlier_filter] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int pick;
    if (!gaps_on) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic kind, input logic nf,
                           input logic [COORD_W-1:0] x, y, z,
                           input logic [ADDR_W-1:0] q);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= {nf, kind};
    s_tdata  <= {2'b00, q, z, y, x};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    gap = pick_gap();
    // keep valid up when the next item follows back to back
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_point(input logic nf, input int x, y, z);
    send_item(KIND_LOAD, nf, COORD_W'(x), COORD_W'(y), COORD_W'(z),
              ADDR_W'($urandom_range(0, MAX_POINTS - 1)));
  endtask

  task automatic classify(input int q);
    send_item(KIND_CLASSIFY, 1'($urandom_range(0, 1)), COORD_W'($urandom),
              COORD_W'($urandom), COORD_W'($urandom), ADDR_W'(q));
  endtask

  // Wait until every classify has delivered its result.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic configure(input int radius, input int min_nb);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_RADIUS;
    cfg_data  <= RADIUS_W'(radius);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_MIN_NB;
    cfg_data  <= RADIUS_W'(min_nb);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_radius = radius;
  endtask

  function automatic int pick_centre(input int spread);
    case ($urandom_range(0, 9))
      0:       return -524288 + spread;
      1:       return 524287 - spread;
      default: return int'($urandom_range(0, 1048575 - 2 * spread)) - 524288 + spread;
    endcase
  endfunction

  function automatic int cluster_coord(input int centre, input int spread);
    return centre + int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  initial begin
    int target, n, nq, spread, cx, cy, cz, pick;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: radius 100, three neighbors. Empty store first.
    classify(0);
    load_point(1'b1, 0, 0, 0);
    load_point(1'b0, 100, 0, 0);     // exactly on the sphere of point 0
    load_point(1'b0, 0, -57, 0);
    load_point(1'b0, 0, 0, 0);       // duplicate of point 0
    load_point(1'b0, 101, 0, 0);     // just outside point 0
    classify(0);
    classify(4);
    classify(3);
    classify(5);
    classify(MAX_POINTS - 1);
    // corners of the coordinate range
    load_point(1'b1, -524288, -524288, -524288);
    load_point(1'b0, 524287, 524287, 524287);
    load_point(1'b0, -524288, -524288, -524288);
    classify(0);
    classify(1);
    classify(2);
    configure(65535, 0);
    classify(1);
    classify(3);
    configure(1, 1023);
    load_point(1'b1, 7, 7, 7);
    load_point(1'b0, 8, 7, 7);
    load_point(1'b0, 7, 7, 7);
    load_point(1'b0, 8, 8, 7);       // diagonal, squared distance two
    classify(0);

    // Random frames: clustered clouds with outliers, then queries.
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 40) begin
        pick = $urandom_range(0, 19);
        cx = (pick == 0) ? 1 : (pick == 1) ? 65535 : $urandom_range(20, 3000);
        pick = $urandom_range(0, 19);
        cy = (pick < 2) ? 0 : (pick == 2) ? 1023 : $urandom_range(1, 6);
        configure(cx, cy);
      end
      gaps_on   = ($urandom_range(0, 99) < 75);
      stalls_on = ($urandom_range(0, 99) < 75);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      case ($urandom_range(0, 4))
        0:       spread = 0;
        1:       spread = cur_radius / 2;
        2:       spread = cur_radius;
        3:       spread = 2 * cur_radius;
        default: spread = 8 * cur_radius;
      endcase
      if (spread > 200000) spread = 200000;
      cx = pick_centre(spread);
      cy = pick_centre(spread);
      cz = pick_centre(spread);
      for (int k = 0; k < n; k++) begin
        // an occasional new frame in mid-cloud restarts the store
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 15)
          load_point(k == 0 || pick < 3, $urandom, $urandom, $urandom);
        else
          load_point(k == 0 || pick < 3, cluster_coord(cx, spread),
                     cluster_coord(cy, spread), cluster_coord(cz, spread));
        if ($urandom_range(0, 99) < 5) classify($urandom_range(0, k + 1));
      end
      nq = $urandom_range(1, (n < 30) ? n + 2 : 30);
      for (int k = 0; k < nq; k++) begin
        if ($urandom_range(0, 99) < 85) classify($urandom_range(0, n - 1));
        else                            classify($urandom_range(n, MAX_POINTS - 1));
      end
    end

    configure(1, 1023);
    classify(3);
    load_point(1'b1, 0, 0, 0);       // new frame empties the store
    classify(0);
    classify(1);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("[radius_outlier_filter] OK");
    else
      $display("[radius_outlier_filter] ERROR");
    $finish;
  end

endmodule
